// ----- rtl/byte_fifo_ecn_marker_assert.svh -----
// assertion macros shared by the byte fifo ecn marker rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef BYTE_FIFO_ECN_MARKER_ASSERT_SVH
`define BYTE_FIFO_ECN_MARKER_ASSERT_SVH

// property must hold at every clock edge outside reset
`define BFEM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bfem_pkg.sv -----
// shared types and constants of the byte fifo ecn marker
// no dependencies; used by every module of the block
`default_nettype none

package bfem_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 256;
  localparam int OCC_W      = 24;
  localparam int TAG_W      = 16;
  localparam int LEN_W      = 16;
  localparam int DRAW_W     = 16;
  localparam int PROB_W     = 17;
  localparam int OCC_PKT_W  = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [OCC_W-1:0] CAPACITY_RESET = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY  = 3'd0,
    CFG_ECN_EN    = 3'd1,
    CFG_MARK_MIN  = 3'd2,
    CFG_MARK_MAX  = 3'd3,
    CFG_MARK_PROB = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_DEQ,
    ST_MARK_GO,
    ST_MARK_WAIT
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [TAG_W-1:0]  packet_tag;
    logic [LEN_W-1:0]  packet_bytes;
    logic [DRAW_W-1:0] random_draw;
  } in_item_t;

  typedef struct packed {
    logic                 enqueue_accepted;
    logic                 out_valid;
    logic [TAG_W-1:0]     out_tag;
    logic [LEN_W-1:0]     out_bytes;
    logic                 ecn_marked;
    logic [OCC_W-1:0]     occupancy_bytes;
    logic [OCC_PKT_W-1:0] occupancy_packets;
  } out_item_t;

  // one descriptor word: length high, tag low
  typedef struct packed {
    logic [LEN_W-1:0] bytes;
    logic [TAG_W-1:0] tag;
  } desc_t;

  typedef struct packed {
    logic [OCC_W-1:0]  capacity;
    logic              ecn_enable;
    logic [OCC_W-1:0]  mark_min;
    logic [OCC_W-1:0]  mark_max;
    logic [PROB_W-1:0] mark_prob;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/bfem_cfg_regs.sv -----
// configuration register file of the byte fifo ecn marker
// depends on bfem_pkg
`default_nettype none

module bfem_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bfem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bfem_pkg::CFG_DATA_W-1:0] cfg_data,
  output bfem_pkg::cfg_t                      cfg
);

  bfem_pkg::cfg_t cfg_r;
  bfem_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (bfem_pkg::cfg_reg_t'(cfg_index))
        bfem_pkg::CFG_CAPACITY:  cfg_nxt.capacity   = cfg_data[bfem_pkg::OCC_W-1:0];
        bfem_pkg::CFG_ECN_EN:    cfg_nxt.ecn_enable = cfg_data[0];
        bfem_pkg::CFG_MARK_MIN:  cfg_nxt.mark_min   = cfg_data[bfem_pkg::OCC_W-1:0];
        bfem_pkg::CFG_MARK_MAX:  cfg_nxt.mark_max   = cfg_data[bfem_pkg::OCC_W-1:0];
        bfem_pkg::CFG_MARK_PROB: cfg_nxt.mark_prob  = cfg_data[bfem_pkg::PROB_W-1:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity   <= bfem_pkg::CAPACITY_RESET;
      cfg_r.ecn_enable <= 1'b0;
      cfg_r.mark_min   <= '0;
      cfg_r.mark_max   <= '0;
      cfg_r.mark_prob  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bfem_desc_ram.sv -----
// descriptor store: simple dual port memory, registered read
// depends on bfem_pkg
`default_nettype none

module bfem_desc_ram #(
  parameter int QUEUE_DEPTH = bfem_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [PTR_W-1:0] waddr,
  input  wire bfem_pkg::desc_t  wdata,
  input  wire logic             re,
  input  wire logic [PTR_W-1:0] raddr,
  output bfem_pkg::desc_t       rdata
);

  bfem_pkg::desc_t mem [QUEUE_DEPTH];
  bfem_pkg::desc_t rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bfem_mark_unit.sv -----
// three stage congestion mark decision: window differences, products, compare
// depends on bfem_pkg
`default_nettype none

module bfem_mark_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [bfem_pkg::OCC_W-1:0]  occ,
  input  wire logic [bfem_pkg::DRAW_W-1:0] draw,
  input  wire bfem_pkg::cfg_t              cfg,
  output logic                             done,
  output logic                             mark
);

  localparam int LHS_W = bfem_pkg::DRAW_W + bfem_pkg::OCC_W;
  localparam int RHS_W = bfem_pkg::PROB_W + bfem_pkg::OCC_W;

  // stage a
  logic                        va_r;
  logic                        above_max_a_r, above_min_a_r, en_a_r;
  logic [bfem_pkg::OCC_W-1:0]  occ_diff_r, win_r;
  logic [bfem_pkg::DRAW_W-1:0] draw_r;
  // stage b
  logic                        vb_r;
  logic                        above_max_b_r, above_min_b_r, en_b_r;
  logic [LHS_W-1:0]            lhs_r;
  logic [RHS_W-1:0]            rhs_r;
  // stage c
  logic                        done_r, mark_r;
  logic                        mark_nxt;

  assign done = done_r;
  assign mark = mark_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      va_r   <= go;
      vb_r   <= va_r;
      done_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      above_max_a_r <= occ > cfg.mark_max;
      above_min_a_r <= occ > cfg.mark_min;
      en_a_r        <= cfg.ecn_enable;
      occ_diff_r    <= occ - cfg.mark_min;
      win_r         <= cfg.mark_max - cfg.mark_min;
      draw_r        <= draw;
    end
  end

  always_ff @(posedge clk) begin
    if (va_r) begin
      above_max_b_r <= above_max_a_r;
      above_min_b_r <= above_min_a_r;
      en_b_r        <= en_a_r;
      lhs_r         <= LHS_W'(draw_r) * LHS_W'(win_r);
      rhs_r         <= RHS_W'(cfg.mark_prob) * RHS_W'(occ_diff_r);
    end
  end

  // window test only counts when min < occ <= max
  assign mark_nxt = en_b_r &
                    (above_max_b_r | (above_min_b_r & (RHS_W'(lhs_r) <= rhs_r)));

  always_ff @(posedge clk) begin
    if (vb_r) begin
      mark_r <= mark_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/byte_fifo_ecn_marker.sv -----
// byte-accounted descriptor fifo with congestion marking on dequeue
// enqueue or empty dequeue result comes from the registered strobe set in ST_ENQ or ST_DEQ;
//   dequeue of a packet answers after the descriptor read and the mark pipeline
// one command at a time; the next start is taken only once busy is low again
// reset: counters, pointers and config to reset values; descriptor memory not cleared
// depends on bfem_pkg, bfem_cfg_regs, bfem_desc_ram, bfem_mark_unit, assert macros
`default_nettype none

`include "byte_fifo_ecn_marker_assert.svh"

module byte_fifo_ecn_marker #(
  parameter int QUEUE_DEPTH = bfem_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command transaction
  input  wire logic                            start,
  output logic                                 busy,
  input  wire bfem_pkg::in_item_t              in_data,
  // result transaction, one cycle wide, cannot be stalled
  output logic                                 out_strobe,
  output bfem_pkg::out_item_t                  out_data,
  // configuration write transaction
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bfem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfem_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W = bfem_pkg::OCC_W;
  localparam int PKT_W = bfem_pkg::OCC_PKT_W;

  // control state
  bfem_pkg::state_t state_r, state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [OCC_W-1:0] bytes_r, bytes_nxt;
  logic             out_strobe_r, out_strobe_nxt;

  // payload registers
  bfem_pkg::in_item_t  item_r, item_nxt;
  bfem_pkg::desc_t     hold_r, hold_nxt;
  bfem_pkg::out_item_t out_r, out_nxt;

  // config and submodule links
  bfem_pkg::cfg_t  cfg;
  bfem_pkg::desc_t ram_rdata;
  bfem_pkg::desc_t ram_wdata;
  logic            ram_we, ram_re;
  logic            mark_go, mark_done, mark_bit;

  // enqueue admission: descriptor slot free and bytes fit the capacity
  logic [OCC_W:0]   enq_sum;
  logic             enq_fits;
  // dequeue: saturating byte subtraction
  logic [OCC_W-1:0] deq_len;
  logic [OCC_W-1:0] deq_bytes;
  // packet count reduced to the output width
  logic [CNT_W+PKT_W-1:0] cnt_ext;

  assign busy       = (state_r != bfem_pkg::ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  assign enq_sum  = {1'b0, bytes_r} + (OCC_W+1)'(item_r.packet_bytes);
  assign enq_fits = (count_r < CNT_W'(QUEUE_DEPTH)) && (enq_sum <= {1'b0, cfg.capacity});
  assign deq_len   = OCC_W'(ram_rdata.bytes);
  assign deq_bytes = (bytes_r >= deq_len) ? (bytes_r - deq_len) : '0;
  assign cnt_ext   = {{PKT_W{1'b0}}, count_nxt};

  assign ram_wdata.bytes = item_r.packet_bytes;
  assign ram_wdata.tag   = item_r.packet_tag;

  bfem_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bfem_desc_ram #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  bfem_mark_unit u_mark (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mark_go),
    .occ   (bytes_r),
    .draw  (item_r.random_draw),
    .cfg   (cfg),
    .done  (mark_done),
    .mark  (mark_bit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfem_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_data.command == bfem_pkg::CMD_DEQ) ? bfem_pkg::ST_DEQ
                                                              : bfem_pkg::ST_ENQ;
        end
      end
      bfem_pkg::ST_ENQ:  state_nxt = bfem_pkg::ST_IDLE;
      bfem_pkg::ST_DEQ: begin
        // empty queue answers right away, otherwise run the mark pipeline
        state_nxt = (count_r == '0) ? bfem_pkg::ST_IDLE : bfem_pkg::ST_MARK_GO;
      end
      bfem_pkg::ST_MARK_GO: state_nxt = bfem_pkg::ST_MARK_WAIT;
      bfem_pkg::ST_MARK_WAIT: begin
        if (mark_done) begin
          state_nxt = bfem_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfem_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    bytes_nxt      = bytes_r;
    item_nxt       = item_r;
    hold_nxt       = hold_r;
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    mark_go        = 1'b0;

    unique case (state_r)
      bfem_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          // descriptor read issued with the accept, data ready in ST_DEQ
          ram_re   = (in_data.command == bfem_pkg::CMD_DEQ);
        end
      end
      bfem_pkg::ST_ENQ: begin
        if (enq_fits) begin
          ram_we    = 1'b1;
          tail_nxt  = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
          bytes_nxt = enq_sum[OCC_W-1:0];
        end
        out_nxt                   = '0;
        out_nxt.enqueue_accepted  = enq_fits;
        out_nxt.occupancy_bytes   = bytes_nxt;
        out_nxt.occupancy_packets = cnt_ext[PKT_W-1:0];
        out_strobe_nxt            = 1'b1;
      end
      bfem_pkg::ST_DEQ: begin
        if (count_r != '0) begin
          head_nxt  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
          bytes_nxt = deq_bytes;
          hold_nxt  = ram_rdata;
        end else begin
          // empty dequeue: no packet, state untouched
          out_nxt                   = '0;
          out_nxt.occupancy_bytes   = bytes_r;
          out_nxt.occupancy_packets = cnt_ext[PKT_W-1:0];
          out_strobe_nxt            = 1'b1;
        end
      end
      bfem_pkg::ST_MARK_GO: begin
        // occupancy after removal is now in bytes_r
        mark_go = 1'b1;
      end
      bfem_pkg::ST_MARK_WAIT: begin
        if (mark_done) begin
          out_nxt.enqueue_accepted  = 1'b0;
          out_nxt.out_valid         = 1'b1;
          out_nxt.out_tag           = hold_r.tag;
          out_nxt.out_bytes         = hold_r.bytes;
          out_nxt.ecn_marked        = mark_bit;
          out_nxt.occupancy_bytes   = bytes_r;
          out_nxt.occupancy_packets = cnt_ext[PKT_W-1:0];
          out_strobe_nxt            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfem_pkg::ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      bytes_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      bytes_r      <= bytes_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  // checks
  `BFEM_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH), "packet count over depth")
  `BFEM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted command not busy")
  `BFEM_ASSERT_NEXT(a_deq_count, clk, rst_n, (state_r == bfem_pkg::ST_DEQ) && (count_r != '0), count_r == $past(count_r) - 1'b1, "dequeue did not pop")
  `BFEM_ASSERT(a_mark_in_wait, clk, rst_n, !mark_done || (state_r == bfem_pkg::ST_MARK_WAIT), "mark result outside wait")

endmodule

`default_nettype wire

// ----- tb/tb_byte_fifo_ecn_marker.sv -----
// self-checking testbench for byte_fifo_ecn_marker: directed command script, then random phases
// depends on bfem_pkg and the byte_fifo_ecn_marker rtl; needs no files or arguments
`default_nettype none

module tb_byte_fifo_ecn_marker;
  timeunit 1ns;
  timeprecision 1ps;

  import bfem_pkg::*;

  localparam int DEPTH = DEFAULT_QUEUE_DEPTH;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // dut ports, all known from time zero
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_strobe;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  byte_fifo_ecn_marker #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow copy of the queue and its registers, updated per accepted transaction
  desc_t shadow_desc [DEPTH];
  int    shadow_head = 0;
  int    shadow_tail = 0;
  int    shadow_pkts = 0;
  int    shadow_occ  = 0;
  cfg_t  shadow_cfg  = '{capacity: CAPACITY_RESET, ecn_enable: 1'b0,
                         mark_min: '0, mark_max: '0, mark_prob: '0};

  // results owed by the dut, oldest first
  out_item_t outcomes_in_flight [$];
  int        mismatch_count = 0;

  // one row of the directed script; preset < 0 keeps the current settings
  typedef struct {
    int        preset;
    in_item_t  cmd;
    bit        typed;
    out_item_t want;
  } script_row_t;

  script_row_t script_rows [$];
  cfg_t        presets [4];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // red-style marking decision on the occupancy left after the pop
  function automatic bit congestion_mark(int occ, logic [DRAW_W-1:0] draw);
    int     lo;
    int     hi;
    longint lhs;
    longint rhs;
    lo = int'(shadow_cfg.mark_min);
    hi = int'(shadow_cfg.mark_max);
    if (!shadow_cfg.ecn_enable) return 1'b0;
    if (occ > hi) return 1'b1;
    if (occ <= lo) return 1'b0;
    // occ sits in (lo, hi], so hi > lo here
    lhs = longint'(draw) * longint'(hi - lo);
    rhs = longint'(shadow_cfg.mark_prob) * longint'(occ - lo);
    return lhs <= rhs;
  endfunction

  // applies one command to the shadow queue and returns the result it owes
  function automatic out_item_t fifo_command_outcome(in_item_t c);
    out_item_t r;
    desc_t     d;
    r = '0;
    if (c.command == CMD_ENQ) begin
      if (shadow_pkts < DEPTH &&
          shadow_occ + int'(c.packet_bytes) <= int'(shadow_cfg.capacity)) begin
        shadow_desc[shadow_tail] = '{bytes: c.packet_bytes, tag: c.packet_tag};
        shadow_tail = (shadow_tail + 1) % DEPTH;
        shadow_pkts++;
        shadow_occ += int'(c.packet_bytes);
        r.enqueue_accepted = 1'b1;
      end
    end else if (shadow_pkts != 0) begin
      d = shadow_desc[shadow_head];
      shadow_head = (shadow_head + 1) % DEPTH;
      shadow_pkts--;
      // clamp at zero, should the byte count ever fall short
      shadow_occ = (shadow_occ >= int'(d.bytes)) ? shadow_occ - int'(d.bytes) : 0;
      r.out_valid  = 1'b1;
      r.out_tag    = d.tag;
      r.out_bytes  = d.bytes;
      r.ecn_marked = congestion_mark(shadow_occ, c.random_draw);
    end
    r.occupancy_bytes   = shadow_occ[OCC_W-1:0];
    r.occupancy_packets = shadow_pkts[OCC_PKT_W-1:0];
    return r;
  endfunction

  function automatic out_item_t res(bit acc, bit vld, int tag, int len, bit mark,
                                    int occ, int pkts);
    out_item_t r;
    r.enqueue_accepted  = acc;
    r.out_valid         = vld;
    r.out_tag           = tag[TAG_W-1:0];
    r.out_bytes         = len[LEN_W-1:0];
    r.ecn_marked        = mark;
    r.occupancy_bytes   = occ[OCC_W-1:0];
    r.occupancy_packets = pkts[OCC_PKT_W-1:0];
    return r;
  endfunction

  function automatic void add_row(int preset, cmd_t op, int tag, int len, int draw,
                                  bit typed = 1'b0, out_item_t want = '0);
    script_row_t s;
    s.preset             = preset;
    s.cmd.command        = op;
    s.cmd.packet_tag     = tag[TAG_W-1:0];
    s.cmd.packet_bytes   = len[LEN_W-1:0];
    s.cmd.random_draw    = draw[DRAW_W-1:0];
    s.typed              = typed;
    s.want               = want;
    script_rows.push_back(s);
  endfunction

  // drives one command until the dut takes it; a typed expectation overrides
  // the shadow queue's result but the shadow state still advances
  task automatic run_command(in_item_t c, bit typed = 1'b0, out_item_t want = '0);
    out_item_t owed;
    start   <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (busy);
    owed = fifo_command_outcome(c);
    outcomes_in_flight.push_back(typed ? want : owed);
  endtask

  // random sender gap with the given chance in percent, start held low during it
  task automatic maybe_idle(int pct);
    if (pct > 0 && $urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CAPACITY:  shadow_cfg.capacity   = val[OCC_W-1:0];
      CFG_ECN_EN:    shadow_cfg.ecn_enable = val[0];
      CFG_MARK_MIN:  shadow_cfg.mark_min   = val[OCC_W-1:0];
      CFG_MARK_MAX:  shadow_cfg.mark_max   = val[OCC_W-1:0];
      CFG_MARK_PROB: shadow_cfg.mark_prob  = val[PROB_W-1:0];
      default: ;
    endcase
  endtask

  // registers change only once every owed result has come back
  task automatic load_settings(cfg_t s);
    start <= 1'b0;
    while (outcomes_in_flight.size() != 0) @(posedge clk);
    write_reg(CFG_CAPACITY,  CFG_DATA_W'(s.capacity));
    write_reg(CFG_ECN_EN,    CFG_DATA_W'(s.ecn_enable));
    write_reg(CFG_MARK_MIN,  CFG_DATA_W'(s.mark_min));
    write_reg(CFG_MARK_MAX,  CFG_DATA_W'(s.mark_max));
    write_reg(CFG_MARK_PROB, CFG_DATA_W'(s.mark_prob));
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    int   span;
    int   lo;
    int   hi;
    int   t;
    case ($urandom_range(0, 5))
      0:       s.capacity = '1;
      1:       s.capacity = '0;
      2:       s.capacity = OCC_W'($urandom_range(1, 100000));
      3:       s.capacity = OCC_W'($urandom_range(100000, 4000000));
      default: s.capacity = OCC_W'($urandom);
    endcase
    s.ecn_enable = ($urandom_range(0, 4) != 0);
    // thresholds mostly within reach of the occupancy, sometimes at the top
    span = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : $urandom_range(0, 3000000);
    lo = $urandom_range(0, span);
    hi = $urandom_range(lo, span);
    if ($urandom_range(0, 5) == 0) begin
      // wrong order: only the above-max test can mark
      t  = lo;
      lo = hi;
      hi = t;
    end
    s.mark_min = OCC_W'(lo);
    s.mark_max = OCC_W'(hi);
    case ($urandom_range(0, 4))
      0:       s.mark_prob = '0;
      1:       s.mark_prob = PROB_W'(65536);
      2:       s.mark_prob = '1;
      3:       s.mark_prob = PROB_W'($urandom_range(0, 65536));
      default: s.mark_prob = PROB_W'($urandom_range(0, 131071));
    endcase
    return s;
  endfunction

  // enqueue share in percent decides whether the queue tends to fill or drain
  function automatic in_item_t random_command(int enq_pct);
    in_item_t c;
    c.command    = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
    c.packet_tag = TAG_W'($urandom);
    case ($urandom_range(0, 9))
      0:          c.packet_bytes = '0;
      1:          c.packet_bytes = '1;
      2, 3, 4, 5: c.packet_bytes = LEN_W'($urandom_range(1, 1500));
      default:    c.packet_bytes = LEN_W'($urandom);
    endcase
    c.random_draw = DRAW_W'($urandom_range(0, 65535));
    return c;
  endfunction

  // result checker: the dut cannot be stalled, so every strobe is a transaction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (outcomes_in_flight.size() == 0) begin
        report_mismatch("result with nothing owed", 1, 0);
      end else begin
        want = outcomes_in_flight.pop_front();
        if (out_data.enqueue_accepted !== want.enqueue_accepted)
          report_mismatch("enqueue_accepted", out_data.enqueue_accepted,
                          want.enqueue_accepted);
        if (out_data.out_valid !== want.out_valid)
          report_mismatch("out_valid", out_data.out_valid, want.out_valid);
        if (out_data.out_tag !== want.out_tag)
          report_mismatch("out_tag", out_data.out_tag, want.out_tag);
        if (out_data.out_bytes !== want.out_bytes)
          report_mismatch("out_bytes", out_data.out_bytes, want.out_bytes);
        if (out_data.ecn_marked !== want.ecn_marked)
          report_mismatch("ecn_marked", out_data.ecn_marked, want.ecn_marked);
        if (out_data.occupancy_bytes !== want.occupancy_bytes)
          report_mismatch("occupancy_bytes", out_data.occupancy_bytes,
                          want.occupancy_bytes);
        if (out_data.occupancy_packets !== want.occupancy_packets)
          report_mismatch("occupancy_packets", out_data.occupancy_packets,
                          want.occupancy_packets);
      end
    end
  end

  // main sequence
  initial begin
    int enq_pct;
    int idle_pct;

    // moderate window, full-strength probability, small capacity
    presets[0] = '{capacity: 24'd1000, ecn_enable: 1'b1, mark_min: 24'd100,
                   mark_max: 24'd500, mark_prob: 17'd65536};
    // capacity cut below what is queued; any nonzero occupancy marks
    presets[1] = '{capacity: 24'd100, ecn_enable: 1'b1, mark_min: 24'd0,
                   mark_max: 24'd0, mark_prob: 17'd0};
    // thresholds in the wrong order, probability above full scale
    presets[2] = '{capacity: 24'hFFFFFF, ecn_enable: 1'b1, mark_min: 24'd5000,
                   mark_max: 24'd1000, mark_prob: 17'h1FFFF};
    // marking switched off, thresholds at their extremes
    presets[3] = '{capacity: 24'hFFFFFF, ecn_enable: 1'b0, mark_min: 24'd0,
                   mark_max: 24'hFFFFFF, mark_prob: 17'h1FFFF};

    // reset settings: empty pops, extreme and zero-length packets
    add_row(-1, CMD_DEQ, 16'h1234, 16'h5678, 0, 1, res(0, 0, 0, 0, 0, 0, 0));
    add_row(-1, CMD_ENQ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
            res(1, 0, 0, 0, 0, 16'hFFFF, 1));
    add_row(-1, CMD_ENQ, 0, 0, 0, 1, res(1, 0, 0, 0, 0, 16'hFFFF, 2));
    add_row(-1, CMD_DEQ, 0, 0, 16'hFFFF, 1,
            res(0, 1, 16'hFFFF, 16'hFFFF, 0, 0, 1));
    add_row(-1, CMD_DEQ, 0, 0, 0, 1, res(0, 1, 0, 0, 0, 0, 0));
    add_row(-1, CMD_DEQ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, res(0, 0, 0, 0, 0, 0, 0));
    // capacity edge: exact fit accepted, one byte over dropped
    add_row(0, CMD_ENQ, 1, 600, 0, 1, res(1, 0, 0, 0, 0, 600, 1));
    add_row(-1, CMD_ENQ, 2, 401, 0, 1, res(0, 0, 0, 0, 0, 600, 1));
    add_row(-1, CMD_ENQ, 3, 400, 0, 1, res(1, 0, 0, 0, 0, 1000, 2));
    add_row(-1, CMD_ENQ, 4, 0, 0, 1, res(1, 0, 0, 0, 0, 1000, 3));
    add_row(-1, CMD_ENQ, 5, 1, 0, 1, res(0, 0, 0, 0, 0, 1000, 3));
    // inside the marking window, lowest and highest draw
    add_row(-1, CMD_DEQ, 0, 0, 0);
    add_row(-1, CMD_ENQ, 6, 300, 0);
    add_row(-1, CMD_DEQ, 0, 0, 16'hFFFF);
    // occupancy above the new capacity: even zero length drops, pops still work
    add_row(1, CMD_ENQ, 7, 0, 0);
    add_row(-1, CMD_DEQ, 0, 0, 123);
    add_row(-1, CMD_DEQ, 0, 0, 456);
    add_row(-1, CMD_ENQ, 8, 100, 0);
    // swapped thresholds
    add_row(2, CMD_ENQ, 9, 16'hFFFF, 0);
    add_row(-1, CMD_DEQ, 0, 0, 16'hFFFF);
    add_row(-1, CMD_DEQ, 0, 0, 0);
    add_row(-1, CMD_ENQ, 10, 3000, 0);
    add_row(-1, CMD_ENQ, 11, 500, 0);
    add_row(-1, CMD_DEQ, 0, 0, 0);
    // marking disabled
    add_row(3, CMD_DEQ, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script_rows[i]) begin
      if (script_rows[i].preset >= 0) load_settings(presets[script_rows[i].preset]);
      run_command(script_rows[i].cmd, script_rows[i].typed, script_rows[i].want);
      maybe_idle(25);
    end

    // random phases, each under fresh settings; the last one runs back to back
    for (int phase = 0; phase < 8; phase++) begin
      load_settings(random_settings());
      case ($urandom_range(0, 3))
        0:       enq_pct = 35;
        1:       enq_pct = 50;
        2:       enq_pct = 65;
        default: enq_pct = 90;
      endcase
      idle_pct = (phase == 7) ? 0 : 20 * $urandom_range(0, 2);
      repeat (250) begin
        run_command(random_command(enq_pct));
        maybe_idle(idle_pct);
      end
    end

    start <= 1'b0;
    while (outcomes_in_flight.size() != 0) @(posedge clk);
    // catch late strays for a bit longer than the longest latency
    repeat (12) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_byte_fifo_ecn_marker passed");
    end else begin
      $display("tb_byte_fifo_ecn_marker failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_byte_fifo_ecn_marker failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/bfem_pkg.sv
rtl/bfem_cfg_regs.sv
rtl/bfem_desc_ram.sv
rtl/bfem_mark_unit.sv
rtl/byte_fifo_ecn_marker.sv
tb/tb_byte_fifo_ecn_marker.sv
